/* rtl/syl_pkg.sv */
package syl_pkg;

    localparam int NumTok    = 100;
    localparam int TokW      = 7;
    localparam int CodeW     = 7;
    localparam int SymW      = 5;
    localparam int NumLetter = 26;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_SYMBOL  = 2'd1,
        OP_EOT     = 2'd2,
        OP_DECRYPT = 2'd3
    } t_opcode;

    typedef enum logic {
        KIND_CODE   = 1'b0,
        KIND_LETTER = 1'b1
    } t_kind;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [SymW-1:0]  symbol;
        logic [TokW-1:0]  token;
        logic [CodeW-1:0] code;
    } t_in_word;

    typedef struct packed {
        logic             kind;
        logic [CodeW-1:0] value;
        logic             last;
    } t_out_word;

    // Token text: up to three letters, each 5 bits, and a length. Letters
    // beyond the length are zero; digit and empty tokens have length 0.
    typedef struct packed {
        logic [1:0]      len;
        logic [SymW-1:0] l0;
        logic [SymW-1:0] l1;
        logic [SymW-1:0] l2;
    } t_tok_text;

    function automatic t_tok_text mk(input int n, input int a, input int b, input int c);
        t_tok_text t;
        t.len = 2'(n);
        t.l0  = SymW'(a);
        t.l1  = SymW'(b);
        t.l2  = SymW'(c);
        return t;
    endfunction

    localparam int A_ = 0, B_ = 1, C_ = 2, D_ = 3, E_ = 4, F_ = 5, G_ = 6, H_ = 7, I_ = 8,
        L_ = 11, M_ = 12, N_ = 13, O_ = 14, R_ = 17, S_ = 18, T_ = 19, U_ = 20,
        V_ = 21, W_ = 22;

    function automatic t_tok_text tok_text(input logic [TokW-1:0] t);
        t_tok_text r;
        r = mk(0, 0, 0, 0);
        if (t < TokW'(NumLetter)) begin
            r = mk(1, int'(t), 0, 0);
        end else begin
            case (t)
                7'd35: r = mk(2, A_, L_, 0);
                7'd36: r = mk(2, A_, N_, 0);
                7'd37: r = mk(3, A_, N_, D_);
                7'd38: r = mk(2, A_, R_, 0);
                7'd39: r = mk(3, A_, R_, E_);
                7'd40: r = mk(2, A_, S_, 0);
                7'd41: r = mk(2, A_, T_, 0);
                7'd42: r = mk(3, A_, T_, E_);
                7'd43: r = mk(3, A_, T_, I_);
                7'd44: r = mk(2, B_, E_, 0);
                7'd45: r = mk(2, C_, A_, 0);
                7'd46: r = mk(2, C_, E_, 0);
                7'd47: r = mk(2, C_, O_, 0);
                7'd48: r = mk(3, C_, O_, M_);
                7'd49: r = mk(2, D_, A_, 0);
                7'd50: r = mk(2, D_, E_, 0);
                7'd51: r = mk(2, E_, A_, 0);
                7'd52: r = mk(2, E_, D_, 0);
                7'd53: r = mk(2, E_, N_, 0);
                7'd54: r = mk(3, E_, N_, T_);
                7'd55: r = mk(2, E_, R_, 0);
                7'd56: r = mk(3, E_, R_, E_);
                7'd57: r = mk(3, E_, R_, S_);
                7'd58: r = mk(2, E_, S_, 0);
                7'd59: r = mk(3, E_, S_, T_);
                7'd60: r = mk(3, H_, A_, S_);
                7'd61: r = mk(2, H_, E_, 0);
                7'd62: r = mk(2, I_, N_, 0);
                7'd63: r = mk(3, I_, N_, G_);
                7'd64: r = mk(3, I_, O_, N_);
                7'd65: r = mk(2, I_, S_, 0);
                7'd66: r = mk(2, I_, T_, 0);
                7'd67: r = mk(3, I_, V_, E_);
                7'd68: r = mk(2, L_, A_, 0);
                7'd69: r = mk(2, L_, E_, 0);
                7'd70: r = mk(2, M_, E_, 0);
                7'd71: r = mk(2, N_, D_, 0);
                7'd72: r = mk(2, N_, E_, 0);
                7'd73: r = mk(2, N_, T_, 0);
                7'd74: r = mk(2, O_, F_, 0);
                7'd75: r = mk(2, O_, N_, 0);
                7'd76: r = mk(2, O_, R_, 0);
                7'd77: r = mk(2, O_, U_, 0);
                7'd78: r = mk(2, R_, A_, 0);
                7'd79: r = mk(2, R_, E_, 0);
                7'd80: r = mk(3, R_, E_, D_);
                7'd81: r = mk(3, R_, E_, S_);
                7'd82: r = mk(2, R_, I_, 0);
                7'd83: r = mk(2, R_, O_, 0);
                7'd84: r = mk(2, S_, E_, 0);
                7'd85: r = mk(2, S_, H_, 0);
                7'd86: r = mk(2, S_, T_, 0);
                7'd87: r = mk(3, S_, T_, O_);
                7'd88: r = mk(2, T_, E_, 0);
                7'd89: r = mk(3, T_, E_, D_);
                7'd90: r = mk(3, T_, E_, R_);
                7'd91: r = mk(2, T_, H_, 0);
                7'd92: r = mk(3, T_, H_, E_);
                7'd93: r = mk(3, T_, H_, I_);
                7'd94: r = mk(3, T_, H_, R_);
                7'd95: r = mk(2, T_, I_, 0);
                7'd96: r = mk(2, T_, O_, 0);
                7'd97: r = mk(2, V_, E_, 0);
                7'd98: r = mk(2, W_, E_, 0);
                default: r = mk(0, 0, 0, 0);
            endcase
        end
        return r;
    endfunction

    // Exact-length search over the syllable part of the ROM; the first
    // token in ROM order wins, as the text of each token is unique anyway.
    function automatic logic [TokW:0] find_tok(input logic [1:0] len,
            input logic [SymW-1:0] a, input logic [SymW-1:0] b,
            input logic [SymW-1:0] c);
        logic [TokW:0] r;
        t_tok_text     t;
        r = '0;
        for (int i = NumTok - 1; i >= 35; i--) begin
            t = tok_text(TokW'(i));
            if (t.len == len && t.l0 == a && t.l1 == b && (len != 2'd3 || t.l2 == c))
                r = {1'b1, TokW'(i)};
        end
        return r;
    endfunction

endpackage

/* rtl/syl_if.sv */
interface syl_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/syllabary_cipher_codec.sv */
// Channel   Dir  Payload                          Handshake
// i_in      in   opcode, symbol, token, code      valid/ready
// o_out     out  kind, value, last                valid/ready
// i_cfg_*   in   encrypt_mode                     write enable
//
// A load, a letter that only fills the window and a decrypt into a free read
// stage do not hold the input; a word emitting codes holds it until its last
// code issues, one map read per code. The read stage expands a decrypt's token
// one letter per cycle while the queue has room, and the next map read waits
// until its last letter is queued. A two-entry output queue follows the read
// stage. Reset is synchronous; the maps are not cleared. An output stall fills
// the queue, which holds the read stage and then the issue stage.
module syllabary_cipher_codec
    import syl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    syl_if.sink        i_in,
    syl_if.source      o_out
);

    logic [CodeW-1:0] r_cft [NumTok];
    logic [TokW-1:0]  r_tfc [NumTok];

    logic            r_mode;
    logic [SymW-1:0] r_p0, r_p1, r_p2, n_p0, n_p1, n_p2;
    logic [1:0]      r_cnt, n_cnt;

    // Issue stage: a held item being worked through.
    logic            r_busy, n_busy;
    t_in_word        r_it;
    logic            r_flush, n_flush;

    // Read stage.
    logic            r_rv, r_rlast, r_rdec;
    logic [1:0]      r_rpos;
    logic [CodeW-1:0] r_rd_code;
    logic [TokW-1:0]  r_rd_tok;

    // Output queue.
    t_out_word  r_q0, r_q1;
    logic [1:0] r_qn;

    t_in_word   in_w, cur;
    logic       take, space, iss, iss_last, iss_dec, done;
    logic [6:0] rd_addr;
    logic [TokW:0] f3, f2;
    logic [1:0] used;
    logic [TokW-1:0] etok;
    t_tok_text  dt;
    t_out_word  rw;
    logic       push, pop;
    logic       rd_free;

    assign in_w = t_in_word'(i_in.data);
    assign cur  = r_busy ? r_it : in_w;
    assign i_in.ready = !r_busy && i_rst_n;
    assign take = i_in.valid && i_in.ready;
    // Issue only when the read stage is empty or hands off its last word this cycle.
    assign space = rd_free;

    always_comb begin
        n_p0 = r_p0; n_p1 = r_p1; n_p2 = r_p2; n_cnt = r_cnt;
        n_busy = r_busy; n_flush = r_flush;
        iss = 1'b0; iss_last = 1'b0; iss_dec = 1'b0; done = 1'b0;
        rd_addr = '0; used = 2'd1; etok = '0;
        f3 = find_tok(2'd3, r_p0, r_p1, r_p2);
        f2 = find_tok(2'd2, r_p0, r_p1, r_p2);
        dt = tok_text(r_rd_tok);
        if (r_busy || take) begin
            case (t_opcode'(cur.opcode))
                OP_LOAD: done = 1'b1;
                OP_DECRYPT: begin
                    // Token read in first pass, letters from the read stage.
                    if (cur.code > CodeW'(NumTok - 1)) done = 1'b1;
                    else if (space) begin
                        iss = 1'b1; iss_dec = 1'b1; iss_last = 1'b1;
                        rd_addr = cur.code; done = 1'b1;
                    end else begin
                        n_busy = 1'b1;
                    end
                end
                default: begin
                    if (!r_busy && t_opcode'(cur.opcode) == OP_SYMBOL
                            && cur.symbol < SymW'(NumLetter)) begin
                        // Append the letter; emission handled from the window.
                        if (r_cnt == 2'd0) n_p0 = cur.symbol;
                        else if (r_cnt == 2'd1) n_p1 = cur.symbol;
                        else n_p2 = cur.symbol;
                        if (r_cnt != 2'd3) n_cnt = r_cnt + 2'd1;
                        n_flush = !r_mode;
                        n_busy  = !r_mode || r_cnt == 2'd2;
                        if (!n_busy) done = 1'b1;
                    end else if (!r_busy) begin
                        n_flush = 1'b1;
                        n_busy  = r_cnt != 2'd0;
                        if (!n_busy) done = 1'b1;
                    end else if (r_cnt == 2'd0) begin
                        n_busy = 1'b0;
                    end else if (space) begin
                        iss = 1'b1;
                        if (r_mode && r_cnt == 2'd3 && f3[TokW]) begin
                            etok = f3[TokW-1:0]; used = 2'd3;
                        end else if (r_mode && r_cnt >= 2'd2 && f2[TokW]) begin
                            etok = f2[TokW-1:0]; used = 2'd2;
                        end else begin
                            etok = TokW'(r_p0); used = 2'd1;
                        end
                        rd_addr = etok;
                        n_cnt = r_cnt - used;
                        case (used)
                            2'd3: begin n_p0 = '0; n_p1 = '0; n_p2 = '0; end
                            2'd2: begin n_p0 = r_p2; n_p1 = '0; n_p2 = '0; end
                            default: begin n_p0 = r_p1; n_p1 = r_p2; n_p2 = '0; end
                        endcase
                        iss_last = !r_flush || n_cnt == 2'd0;
                        if (iss_last) n_busy = 1'b0;
                    end
                end
            endcase
            if (done) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && t_opcode'(in_w.opcode) == OP_LOAD
                && in_w.token < TokW'(NumTok) && in_w.code < CodeW'(NumTok)) begin
            r_cft[in_w.token] <= in_w.code;
            r_tfc[in_w.code]  <= in_w.token;
        end
        if (iss) begin
            r_rd_code <= r_cft[rd_addr];
            r_rd_tok  <= r_tfc[rd_addr];
        end
        if (take) r_it <= in_w;
    end

    // Decrypt expands the read token, up to three letters, at the read stage.
    logic [1:0] dlen;
    logic       hold_rd;
    assign dlen = dt.len;
    always_comb begin
        rw.kind = KIND_CODE; rw.value = r_rd_code; rw.last = r_rlast;
        if (r_rdec) begin
            rw.kind  = KIND_LETTER;
            rw.value = CodeW'(r_rpos == 2'd0 ? dt.l0 : (r_rpos == 2'd1 ? dt.l1 : dt.l2));
            rw.last  = (r_rpos + 2'd1) == dlen;
        end
    end
    assign push = r_rv && (!r_rdec || dlen != 2'd0) && r_qn != 2'd2;
    assign pop  = o_out.valid && o_out.ready;
    assign o_out.valid = r_qn != 2'd0;
    assign o_out.data  = r_q0;

    assign rd_free = !r_rv || (r_rdec ? (dlen == 2'd0 || (push && rw.last))
                                      : push);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1; r_cnt <= '0; r_p0 <= '0; r_p1 <= '0; r_p2 <= '0;
            r_busy <= 1'b0; r_flush <= 1'b0;
            r_rv <= 1'b0; r_rpos <= '0; r_rdec <= 1'b0; r_rlast <= 1'b0;
            r_qn <= '0;
        end else begin
            if (i_cfg_we) r_mode <= i_cfg_data;
            r_p0 <= n_p0; r_p1 <= n_p1; r_p2 <= n_p2; r_cnt <= n_cnt;
            r_busy <= n_busy; r_flush <= n_flush;
            if (iss) begin
                r_rv <= 1'b1; r_rdec <= iss_dec; r_rlast <= iss_last; r_rpos <= '0;
            end else if (rd_free) begin
                r_rv <= 1'b0;
            end else if (push) begin
                r_rpos <= r_rpos + 2'd1;
            end
            case ({push, pop})
                2'b10: begin
                    if (r_qn == 2'd0) r_q0 <= rw; else r_q1 <= rw;
                    r_qn <= r_qn + 2'd1;
                end
                2'b01: begin r_q0 <= r_q1; r_qn <= r_qn - 2'd1; end
                2'b11: begin
                    if (r_qn == 2'd1) r_q0 <= rw; else begin r_q0 <= r_q1; r_q1 <= rw; end
                end
                default: ;
            endcase
        end
    end

    // The issue stage waits for the read stage to drain before it issues.
    always_comb hold_rd = r_rv && !rd_free && iss;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_qn != 2'd3)
        else $error("output queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !hold_rd)
        else $error("issue over a busy read stage");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_busy |-> !i_in.ready)
        else $error("input taken while busy");

endmodule
